@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the bitmap range engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of aclk, masked while reset is asserted.
`define BRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check in the cycle after the trigger, masked while reset is asserted.
`define BRE_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/bre_pkg.sv @@
// ----------------------------------------------------------------------------
// bre_pkg
// Types, codes and sizes shared by the bitmap range engine modules.
// ----------------------------------------------------------------------------
package bre_pkg;

    localparam int STORE_BYTES = 512;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int STORE_BITS  = STORE_BYTES * 8;
    localparam int BIT_W       = 12;
    localparam int CNT_W       = 13;
    localparam int SUM_W       = 14;
    localparam int IN_W        = 64;
    localparam int OUT_W       = 16;

    // commands
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_SET   = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_COPY  = 3'd4;

    // result status
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_RANGE   = 2'd1;
    localparam logic [1:0] STAT_OVERLAP = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_PRIME,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } bre_state_t;

    // input word, command in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0] bit_count;
        logic [BIT_W-1:0] dest_bit;
        logic [BIT_W-1:0] src_bit;
        logic [7:0]       write_data;
        logic [8:0]       byte_address;
        logic [2:0]       command;
    } bre_item_t;

    // result word, read_data in the lowest bits
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
    } bre_res_t;

    typedef struct packed {
        logic                re_a;
        logic [STORE_AW-1:0] addr_a;
        logic                re_b;
        logic [STORE_AW-1:0] addr_b;
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
    } bre_mem_req_t;

endpackage

@@ rtl/bre_store.sv @@
// ----------------------------------------------------------------------------
// bre_store
// Bitmap byte store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bre_store import bre_pkg::*; (
    input  logic         aclk,
    input  bre_mem_req_t mem_req,
    output logic [7:0]   rd_a,
    output logic [7:0]   rd_b
);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    // read data holds until the next read on that port
    always_ff @(posedge aclk) begin
        if (mem_req.re_a) begin
            rd_a_reg <= mem[mem_req.addr_a];
        end
        if (mem_req.re_b) begin
            rd_b_reg <= mem[mem_req.addr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

@@ rtl/bre_seq.sv @@
// ----------------------------------------------------------------------------
// bre_seq
// Command sequencer: range checks, clearing pass and the byte-per-cycle
// read-modify-write loop over the store.
// ----------------------------------------------------------------------------
module bre_seq import bre_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  bre_item_t    item,
    input  logic         out_free,
    input  logic [7:0]   rd_a,
    input  logic [7:0]   rd_b,
    output logic         idle,
    output bre_mem_req_t mem_req,
    output logic         res_valid,
    output bre_res_t     res
);

    bre_state_t          state_reg, state_next;
    logic [STORE_AW-1:0] clr_reg;
    logic                p_valid_reg;

    bre_item_t           item_reg;
    logic [1:0]          status_reg;
    logic [STORE_AW-1:0] j_reg;
    logic [STORE_AW-1:0] last_j_reg;
    logic [STORE_AW-1:0] q_reg;
    logic [2:0]          sh_reg;
    logic [2:0]          lo_reg;
    logic [2:0]          hi_reg;
    logic                first_reg;
    logic [7:0]          prev_reg;
    logic [STORE_AW-1:0] p_j_reg;
    logic                p_first_reg;
    logic                p_last_reg;

    // decode of the held word
    logic                is_copy;
    logic [BIT_W-1:0]    dst_eff;
    logic [SUM_W-1:0]    src_end;
    logic [SUM_W-1:0]    dst_end;
    logic [SUM_W-1:0]    eff_end;
    logic [SUM_W-1:0]    tail_bit;
    logic [BIT_W-1:0]    delta;
    logic                fits_src;
    logic                fits_dst;
    logic                overlap;
    logic                addr_ok;
    logic                cnt_zero;
    logic [1:0]          dec_status;
    logic                dec_run;

    // merge path
    logic [15:0]         win;
    logic [7:0]          src_bits;
    logic [7:0]          mask;
    logic [7:0]          merged;

    always_comb begin
        is_copy  = (item_reg.command == CMD_COPY);
        dst_eff  = is_copy ? item_reg.dest_bit : item_reg.src_bit;
        src_end  = {2'b00, item_reg.src_bit} + {1'b0, item_reg.bit_count};
        dst_end  = {2'b00, item_reg.dest_bit} + {1'b0, item_reg.bit_count};
        eff_end  = is_copy ? dst_end : src_end;
        tail_bit = eff_end - SUM_W'(1);
        delta    = item_reg.src_bit - item_reg.dest_bit;
        fits_src = (src_end <= SUM_W'(STORE_BITS));
        fits_dst = (dst_end <= SUM_W'(STORE_BITS));
        overlap  = ({2'b00, item_reg.src_bit} < dst_end)
                && ({2'b00, item_reg.dest_bit} < src_end);
        addr_ok  = ({1'b0, item_reg.byte_address} < 10'(STORE_BYTES));
        cnt_zero = (item_reg.bit_count == '0);
    end

    always_comb begin
        dec_status = STAT_DONE;
        dec_run    = 1'b0;
        unique case (item_reg.command) inside
            CMD_WRITE, CMD_READ: begin
                if (!addr_ok) begin
                    dec_status = STAT_RANGE;
                end
            end
            CMD_SET, CMD_CLEAR: begin
                if (!cnt_zero) begin
                    if (!fits_src) begin
                        dec_status = STAT_RANGE;
                    end else begin
                        dec_run = 1'b1;
                    end
                end
            end
            CMD_COPY: begin
                if (!cnt_zero) begin
                    if (!fits_src || !fits_dst) begin
                        dec_status = STAT_RANGE;
                    end else if (overlap) begin
                        dec_status = STAT_OVERLAP;
                    end else begin
                        dec_run = 1'b1;
                    end
                end
            end
            default: begin
                dec_status = STAT_DONE;
            end
        endcase
    end

    // destination byte = old bits outside the range, new bits inside
    always_comb begin
        win      = {rd_b, prev_reg} >> sh_reg;
        src_bits = is_copy ? win[7:0]
                 : ((item_reg.command == CMD_SET) ? 8'hFF : 8'h00);
        mask     = (p_first_reg ? (8'hFF << lo_reg) : 8'hFF)
                 & (p_last_reg ? (8'hFF >> (3'd7 - hi_reg)) : 8'hFF);
        merged   = (rd_a & ~mask) | (src_bits & mask);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == STORE_AW'(STORE_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = dec_run ? S_PRIME : S_FINISH;
            end
            S_PRIME: begin
                state_next = S_RUN;
            end
            S_RUN: begin
                if (j_reg == last_j_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_req   = '0;
        idle      = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                mem_req.wdata = 8'h00;
            end
            S_IDLE: begin
                idle = 1'b1;
            end
            S_DECODE: begin
                if (addr_ok && item_reg.command == CMD_WRITE) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = item_reg.byte_address[STORE_AW-1:0];
                    mem_req.wdata = item_reg.write_data;
                end
                if (addr_ok && item_reg.command == CMD_READ) begin
                    mem_req.re_a   = 1'b1;
                    mem_req.addr_a = item_reg.byte_address[STORE_AW-1:0];
                end
            end
            S_PRIME: begin
                mem_req.re_b   = 1'b1;
                mem_req.addr_b = q_reg;
            end
            S_RUN: begin
                mem_req.re_a   = 1'b1;
                mem_req.addr_a = j_reg;
                mem_req.re_b   = 1'b1;
                mem_req.addr_b = q_reg;
                mem_req.we     = p_valid_reg;
                mem_req.waddr  = p_j_reg;
                mem_req.wdata  = merged;
            end
            S_DRAIN: begin
                mem_req.we    = p_valid_reg;
                mem_req.waddr = p_j_reg;
                mem_req.wdata = merged;
            end
            S_FINISH: begin
                res_valid = out_free;
            end
            default: begin
                idle = 1'b0;
            end
        endcase
    end

    assign res.status    = status_reg;
    assign res.read_data = (item_reg.command == CMD_READ && status_reg == STAT_DONE)
                         ? rd_a : 8'h00;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            p_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_valid_reg <= (state_reg == S_RUN);
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + STORE_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            item_reg <= item;
        end
        if (state_reg == S_DECODE) begin
            status_reg <= dec_status;
            j_reg      <= dst_eff[BIT_W-1:3];
            last_j_reg <= tail_bit[BIT_W-1:3];
            q_reg      <= dst_eff[BIT_W-1:3] + delta[BIT_W-1:3];
            sh_reg     <= delta[2:0];
            lo_reg     <= dst_eff[2:0];
            hi_reg     <= tail_bit[2:0];
            first_reg  <= 1'b1;
        end
        if (state_reg == S_PRIME) begin
            q_reg <= q_reg + STORE_AW'(1);
        end
        if (state_reg == S_RUN) begin
            // advance one destination byte, slide the source window
            j_reg       <= j_reg + STORE_AW'(1);
            q_reg       <= q_reg + STORE_AW'(1);
            prev_reg    <= rd_b;
            first_reg   <= 1'b0;
            p_j_reg     <= j_reg;
            p_first_reg <= first_reg;
            p_last_reg  <= (j_reg == last_j_reg);
        end
    end

endmodule

@@ rtl/bitmap_range_engine_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_range_engine_top
// Bit store of 512 bytes with byte write/read and bit range set, clear, copy.
// ----------------------------------------------------------------------------
// One word is taken at a time and gives one result word. Write byte, read
// byte, refused and zero-count commands go from decode straight to the
// result. Set, clear and copy walk the destination range one store byte
// per cycle through a two-read, one-write memory; the range touches at
// most 512 destination bytes. After reset a clearing pass zeroes the
// store, with s_tready low. A finished result sits in the output register
// while the next word is taken.
`include "assert_macros.svh"

module bitmap_range_engine_top import bre_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // command[2:0], byte_address[11:3], write_data[19:12], src_bit[31:20],
    // dest_bit[43:32], bit_count[56:44], zero fill above
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // read_data[7:0], status[9:8], zero fill above
    output logic [OUT_W-1:0] m_tdata
);

    bre_item_t        item;
    bre_res_t         res;
    bre_mem_req_t     mem_req;
    logic [7:0]       rd_a;
    logic [7:0]       rd_b;
    logic             idle;
    logic             start;
    logic             out_free;
    logic             res_valid;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    assign item     = bre_item_t'(s_tdata[$bits(bre_item_t)-1:0]);
    assign s_tready = idle;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    bre_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .item      (item),
        .out_free  (out_free),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .idle      (idle),
        .mem_req   (mem_req),
        .res_valid (res_valid),
        .res       (res)
    );

    bre_store u_store (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_a    (rd_a),
        .rd_b    (rd_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= OUT_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BRE_ASSERT(a_res_room, !res_valid || out_free, "result produced with output held")
    `BRE_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "word taken while busy")
    `BRE_ASSERT(a_no_write_idle, !mem_req.we || !s_tready, "store written while idle")

endmodule
